>>> design/ema_pkg.sv
`timescale 1ns / 1ps

package ema_pkg;

    // Fixed field widths
    localparam int ADDR_W  = 24;
    localparam int LOST_W  = 32;
    localparam int LIMIT_W = 6;
    localparam int USED_W  = 6;
    localparam int ALU_W   = 32;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FIT  = 2'd1,
        ST_LOST    = 2'd2,
        ST_BAD_ARG = 2'd3
    } t_status;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    // One free extent as held in the map memory
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] length;
    } t_extent;

    typedef struct packed {
        t_cmd              command;
        logic [ADDR_W-1:0] start_offset;
        logic [ADDR_W-1:0] request_size;
    } t_request;

    typedef struct packed {
        logic [ADDR_W-1:0] granted_start;
        t_status           status;
        logic [USED_W-1:0] entries_in_use;
        logic [LOST_W-1:0] lost_units;
    } t_result;

endpackage

>>> design/extent_map_allocator_unit.sv
`timescale 1ns / 1ps

// First-fit allocator over a sorted map of free extents held in a single-port-write,
// registered-read memory. One request is handled at a time; the input stalls while
// it is in flight. A request reads one extent per cycle until it finds its place, then
// trims, merges, closes the gap or opens a slot by rippling the following extents one
// per cycle; a free that needs a new slot when the map is at its limit is counted as
// lost. All sums and compares of sizes go through one shared 32-bit adder. The extent
// memory needs no clearing after reset: only entries below the current count are ever
// read. A finished result waits in an output register so the next request can be
// taken while the previous one is still pending downstream.
module extent_map_allocator_unit #(
    parameter int ENTRIES = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ema_pkg::t_request             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ema_pkg::t_result              o_out_data,
    input  logic                          i_cfg_we,
    input  logic [ema_pkg::LIMIT_W-1:0]   i_cfg_wdata
);

    import ema_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int EXT_W = $bits(t_extent);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_TRIM,
        S_TAIL,
        S_JOIN,
        S_HEAD,
        S_SHIFT,
        S_INS,
        S_LOST,
        S_FIN
    } t_state;

    t_state            r_state;
    t_cmd              r_cmd;
    logic [ADDR_W-1:0] r_off;
    logic [ADDR_W-1:0] r_size;
    logic [ADDR_W:0]   r_offend;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_count;
    t_extent           r_hold;
    logic [ADDR_W-1:0] r_aux;
    logic [LOST_W-1:0] r_lost;
    logic [LIMIT_W-1:0] r_limit;
    logic [ADDR_W-1:0] r_granted;
    t_status           r_status;
    logic              r_out_valid;
    t_result           r_out;

    t_alu_op           alu_op;
    logic [ALU_W-1:0]  alu_a;
    logic [ALU_W-1:0]  alu_b;
    logic [ALU_W-1:0]  alu_res;
    logic              alu_carry;

    logic              mem_we;
    t_extent           mem_wdata;
    logic [EXT_W-1:0]  mem_rdata;
    logic [CNT_W:0]    n_raddr;
    t_extent           q;

    logic [CNT_W:0]    idx_p1;
    logic [CNT_W:0]    idx_p2;
    logic              scan_end;
    logic              has_next;
    logic              list_full;
    logic              end_hit;
    logic              head_hit;
    logic              off_below;
    logic              fits;
    logic              exact;
    logic              tail_join;
    logic              ins_now;
    logic              bad_arg;
    logic [LOST_W-1:0] lost_sat;

    assign q = t_extent'(mem_rdata);

    // Scan and ripple helpers
    assign idx_p1    = {1'b0, r_idx} + (CNT_W + 1)'(1);
    assign idx_p2    = {1'b0, r_idx} + (CNT_W + 1)'(2);
    assign scan_end  = (r_idx >= r_count);
    assign has_next  = (idx_p1 < {1'b0, r_count});
    assign list_full = (CMP_W'(r_count) >= CMP_W'(r_limit)) ||
                       (r_count >= CNT_W'(ENTRIES));
    assign end_hit   = (alu_res[ADDR_W:0] == {1'b0, r_off});
    assign head_hit  = (r_offend == {1'b0, q.start});
    assign off_below = (r_off < q.start);
    assign fits      = alu_carry;
    assign exact     = (alu_res == '0);
    assign tail_join = has_next && (r_offend == {1'b0, q.start});
    assign ins_now   = (r_cmd == CMD_FREE) && !list_full &&
                       (scan_end || (!end_hit && !head_hit && off_below));
    assign lost_sat  = alu_carry ? '1 : alu_res;
    assign bad_arg   = (i_in_data.request_size == '0) ||
                       ((i_in_data.command == CMD_FREE) &&
                        ((i_in_data.start_offset == '0) ||
                         (alu_res[ADDR_W] && (alu_res[ADDR_W-1:0] != '0))));

    // Steer the shared adder
    always_comb begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        unique case (r_state)
            S_IDLE: begin
                alu_a = ALU_W'(i_in_data.start_offset);
                alu_b = ALU_W'(i_in_data.request_size);
            end
            S_SCAN: begin
                if (r_cmd == CMD_FREE) begin
                    alu_a = ALU_W'(q.start);
                    alu_b = ALU_W'(q.length);
                end else begin
                    alu_op = ALU_SUB;
                    alu_a  = ALU_W'(q.length);
                    alu_b  = ALU_W'(r_size);
                end
            end
            S_TRIM: begin
                alu_a = ALU_W'(r_hold.start);
                alu_b = ALU_W'(r_size);
            end
            S_TAIL, S_HEAD: begin
                alu_a = ALU_W'(r_hold.length);
                alu_b = ALU_W'(r_size);
            end
            S_JOIN: begin
                alu_a = ALU_W'(r_hold.length);
                alu_b = ALU_W'(r_aux);
            end
            S_LOST: begin
                alu_a = r_lost;
                alu_b = ALU_W'(r_size);
            end
            default: begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    // Memory write and read address per state
    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = r_hold;
        n_raddr   = idx_p1;
        unique case (r_state)
            S_IDLE: n_raddr = '0;
            S_SCAN: begin
                if (ins_now) begin
                    mem_we    = 1'b1;
                    mem_wdata = '{start: r_off, length: r_size};
                end
            end
            S_TRIM: begin
                mem_we    = 1'b1;
                mem_wdata = '{start: alu_res[ADDR_W-1:0], length: r_hold.length};
            end
            S_TAIL: begin
                if (!tail_join) begin
                    mem_we    = 1'b1;
                    mem_wdata = '{start: r_hold.start, length: alu_res[ADDR_W-1:0]};
                end
            end
            S_JOIN: begin
                mem_we    = 1'b1;
                mem_wdata = '{start: r_hold.start, length: alu_res[ADDR_W-1:0]};
                n_raddr   = idx_p2;
            end
            S_HEAD: begin
                mem_we    = 1'b1;
                mem_wdata = '{start: r_off, length: alu_res[ADDR_W-1:0]};
            end
            S_SHIFT: begin
                n_raddr = idx_p2;
                if (has_next) begin
                    mem_we    = 1'b1;
                    mem_wdata = q;
                end
            end
            S_INS: mem_we = 1'b1;
            default: mem_we = 1'b0;
        endcase
    end

    ema_alu u_alu (
        .i_op    (alu_op),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_res   (alu_res),
        .o_carry (alu_carry)
    );

    ema_mem #(
        .DEPTH (ENTRIES),
        .WIDTH (EXT_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_idx[IDX_W-1:0]),
        .i_wdata (mem_wdata),
        .i_raddr (n_raddr[IDX_W-1:0]),
        .o_rdata (mem_rdata)
    );

    // Hold the extent limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_W'(32);
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_lost      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the result beat once taken, unless a new one replaces it
            if (r_out_valid && !i_out_stall && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd     <= i_in_data.command;
                        r_off     <= i_in_data.start_offset;
                        r_size    <= i_in_data.request_size;
                        r_offend  <= alu_res[ADDR_W:0];
                        r_idx     <= '0;
                        r_granted <= '0;
                        if (bad_arg) begin
                            r_status <= ST_BAD_ARG;
                            r_state  <= S_FIN;
                        end else begin
                            r_status <= ST_OK;
                            r_state  <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_cmd == CMD_ALLOC) begin
                        if (scan_end) begin
                            r_status <= ST_NO_FIT;
                            r_state  <= S_FIN;
                        end else if (fits) begin
                            r_granted <= q.start;
                            if (exact) begin
                                r_state <= S_SHIFT;
                            end else begin
                                r_hold  <= '{start: q.start,
                                             length: alu_res[ADDR_W-1:0]};
                                r_state <= S_TRIM;
                            end
                        end else begin
                            r_idx <= idx_p1[CNT_W-1:0];
                        end
                    end else begin
                        if (!scan_end && end_hit) begin
                            r_hold  <= q;
                            r_state <= S_TAIL;
                        end else if (!scan_end && head_hit) begin
                            r_hold  <= q;
                            r_state <= S_HEAD;
                        end else if (scan_end || off_below) begin
                            if (list_full) begin
                                r_state <= S_LOST;
                            end else if (scan_end) begin
                                r_count <= r_count + CNT_W'(1);
                                r_state <= S_FIN;
                            end else begin
                                r_hold  <= q;
                                r_idx   <= idx_p1[CNT_W-1:0];
                                r_state <= S_INS;
                            end
                        end else begin
                            r_idx <= idx_p1[CNT_W-1:0];
                        end
                    end
                end
                S_TRIM: r_state <= S_FIN;
                S_TAIL: begin
                    r_hold.length <= alu_res[ADDR_W-1:0];
                    r_aux         <= q.length;
                    r_state       <= tail_join ? S_JOIN : S_FIN;
                end
                S_JOIN: begin
                    r_idx   <= idx_p1[CNT_W-1:0];
                    r_state <= S_SHIFT;
                end
                S_HEAD: r_state <= S_FIN;
                S_SHIFT: begin
                    // Close the gap one extent per cycle
                    if (has_next) begin
                        r_idx <= idx_p1[CNT_W-1:0];
                    end else begin
                        r_count <= r_count - CNT_W'(1);
                        r_state <= S_FIN;
                    end
                end
                S_INS: begin
                    // Ripple the displaced extents up one slot
                    if (scan_end) begin
                        r_count <= r_count + CNT_W'(1);
                        r_state <= S_FIN;
                    end else begin
                        r_hold <= q;
                        r_idx  <= idx_p1[CNT_W-1:0];
                    end
                end
                S_LOST: begin
                    r_lost   <= lost_sat;
                    r_status <= ST_LOST;
                    r_state  <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out.granted_start  <= r_granted;
                        r_out.status         <= r_status;
                        r_out.entries_in_use <= USED_W'(r_count);
                        r_out.lost_units     <= r_lost;
                        r_out_valid          <= 1'b1;
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Extent count stays within the map
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTRIES))
        else $error("extent count beyond map depth");

    // Count moves by at most one per cycle
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_count == $past(r_count)) ||
                 (r_count == $past(r_count) + CNT_W'(1)) ||
                 (r_count == $past(r_count) - CNT_W'(1)))
        else $error("extent count jumped");

    // Lost total never decreases
    a_lost_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_lost >= $past(r_lost))
        else $error("lost total decreased");

    // Insertion ripple only runs with a free slot
    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |-> (r_count < CNT_W'(ENTRIES)))
        else $error("insert into full map");

endmodule

>>> design/ema_mem.sv
`timescale 1ns / 1ps

module ema_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 48,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, old data on a same-address write
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/ema_alu.sv
`timescale 1ns / 1ps

module ema_alu (
    input  ema_pkg::t_alu_op           i_op,
    input  logic [ema_pkg::ALU_W-1:0]  i_a,
    input  logic [ema_pkg::ALU_W-1:0]  i_b,
    output logic [ema_pkg::ALU_W-1:0]  o_res,
    output logic                       o_carry
);

    import ema_pkg::*;

    logic [ALU_W:0] sum;

    // Add, or subtract as a + ~b + 1; carry high on subtract means a >= b
    always_comb begin
        sum = '0;
        unique case (i_op)
            ALU_ADD: sum = {1'b0, i_a} + {1'b0, i_b};
            ALU_SUB: sum = {1'b0, i_a} + {1'b0, ~i_b} + (ALU_W + 1)'(1);
        endcase
    end

    assign o_res   = sum[ALU_W-1:0];
    assign o_carry = sum[ALU_W];

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ema_pkg::*;

    localparam int ENTRIES      = 32;
    localparam int HALF_PERIOD  = 6;
    localparam int CLK_PERIOD   = 2 * HALF_PERIOD;
    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int MAX_LINES    = 40;
    localparam logic [ADDR_W:0] SPACE = {1'b1, {ADDR_W{1'b0}}};

    // Free-extent ledger: mirrors the map and queues the result of every accepted beat
    class extent_ledger;
        logic [ADDR_W-1:0] ext_start [ENTRIES];
        logic [ADDR_W-1:0] ext_len   [ENTRIES];
        int unsigned       ext_count;
        logic [LOST_W-1:0] lost_total;
        logic [LIMIT_W-1:0] limit_reg;
        t_result           due_results [$];
        int unsigned       mismatches;

        function new();
            ext_count  = 0;
            lost_total = '0;
            limit_reg  = LIMIT_W'(32);
            mismatches = 0;
        endfunction

        function void set_limit(input logic [LIMIT_W-1:0] value);
            limit_reg = value;
        endfunction

        function int unsigned pending();
            return due_results.size();
        endfunction

        // Close the gap left by entry idx
        function void drop_entry(input int unsigned idx);
            int unsigned k;
            for (k = idx; k + 1 < ext_count; k++) begin
                ext_start[k] = ext_start[k + 1];
                ext_len[k]   = ext_len[k + 1];
            end
            if (ext_count > 0) ext_count--;
        endfunction

        // Merge a freed range into the map, or insert it, or count it as lost
        function t_status release_extent(input logic [ADDR_W-1:0] off,
                                         input logic [ADDR_W-1:0] size);
            int unsigned cap, n, i, k;
            logic [ADDR_W:0] tail;
            logic [LOST_W:0] sum;
            cap = (limit_reg < ENTRIES) ? limit_reg : ENTRIES;
            n = ext_count;
            for (i = 0; i < n; i++) begin
                tail = {1'b0, ext_start[i]} + ext_len[i];
                if (tail == {1'b0, off}) begin
                    ext_len[i] = ext_len[i] + size;
                    if (i + 1 < n &&
                        {1'b0, ext_start[i]} + ext_len[i] == {1'b0, ext_start[i + 1]}) begin
                        ext_len[i] = ext_len[i] + ext_len[i + 1];
                        drop_entry(i + 1);
                    end
                    return ST_OK;
                end
                if ({1'b0, off} + size == {1'b0, ext_start[i]}) begin
                    ext_len[i]   = ext_len[i] + size;
                    ext_start[i] = off;
                    return ST_OK;
                end
                if (off < ext_start[i]) break;
            end
            if (n >= cap) begin
                sum = {1'b0, lost_total} + size;
                lost_total = sum[LOST_W] ? '1 : sum[LOST_W-1:0];
                return ST_LOST;
            end
            for (k = n; k > i; k--) begin
                ext_start[k] = ext_start[k - 1];
                ext_len[k]   = ext_len[k - 1];
            end
            ext_start[i] = off;
            ext_len[i]   = size;
            ext_count    = n + 1;
            return ST_OK;
        endfunction

        // Apply one accepted request beat and queue the result it must produce
        function void take_request(input t_request req);
            t_result     want;
            int unsigned i;
            want.granted_start = '0;
            if (req.request_size == '0) begin
                want.status = ST_BAD_ARG;
            end else if (req.command == CMD_ALLOC) begin
                want.status = ST_NO_FIT;
                for (i = 0; i < ext_count; i++) begin
                    if (ext_len[i] >= req.request_size) begin
                        want.granted_start = ext_start[i];
                        if (ext_len[i] > req.request_size) begin
                            ext_start[i] = ext_start[i] + req.request_size;
                            ext_len[i]   = ext_len[i] - req.request_size;
                        end else begin
                            drop_entry(i);
                        end
                        want.status = ST_OK;
                        break;
                    end
                end
            end else if (req.start_offset == '0 ||
                         {1'b0, req.start_offset} + req.request_size > SPACE) begin
                want.status = ST_BAD_ARG;
            end else begin
                want.status = release_extent(req.start_offset, req.request_size);
            end
            want.entries_in_use = USED_W'(ext_count);
            want.lost_units     = lost_total;
            due_results.push_back(want);
        endfunction

        task report_mismatch(input string msg);
            if (mismatches < MAX_LINES) $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        // Compare one result beat against the oldest queued result
        task check_result(input t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
                return;
            end
            want = due_results.pop_front();
            if (got.granted_start !== want.granted_start)
                report_mismatch($sformatf("granted_start %h, want %h",
                                          got.granted_start, want.granted_start));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.entries_in_use !== want.entries_in_use)
                report_mismatch($sformatf("entries_in_use %0d, want %0d",
                                          got.entries_in_use, want.entries_in_use));
            if (got.lost_units !== want.lost_units)
                report_mismatch($sformatf("lost_units %h, want %h",
                                          got.lost_units, want.lost_units));
        endtask
    endclass

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    t_request           i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_result            o_out_data;
    logic               i_cfg_we    = 1'b0;
    logic [LIMIT_W-1:0] i_cfg_wdata = '0;

    extent_ledger ledger = new();

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned hold_asked    = 0;
    int unsigned hold_done     = 0;
    int unsigned hold_left     = 0;

    extent_map_allocator_unit #(
        .ENTRIES(ENTRIES)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Check result beats; stall at random or hold off for a long stretch on request
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) ledger.check_result(o_out_data);
        if (hold_left == 0 && hold_done != hold_asked) begin
            hold_done = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic t_request make_beat(input t_cmd cmd, input int unsigned off,
                                           input int unsigned size);
        t_request req;
        req.command      = cmd;
        req.start_offset = ADDR_W'(off);
        req.request_size = ADDR_W'(size);
        return req;
    endfunction

    // Pick a request that mostly lands on the current map: abutting frees, fitting allocs
    function automatic t_request pick_request(input int unsigned free_pct, input bit flood);
        t_request        req;
        int unsigned     roll, idx, cap;
        logic [ADDR_W:0] tail;
        req.command      = CMD_ALLOC;
        req.start_offset = ADDR_W'($urandom);
        req.request_size = ADDR_W'($urandom_range(1, 4096));
        roll = $urandom_range(99);
        if (flood && roll < 90) begin
            // Full-space free that can merge nowhere
            req.command      = CMD_FREE;
            req.start_offset = ADDR_W'(1);
            req.request_size = '1;
            return req;
        end
        if (roll < 5) begin
            // Malformed or wide-open requests
            req.command = t_cmd'($urandom_range(1));
            case ($urandom_range(3))
                0: req.request_size = '0;
                1: begin
                    req.command      = CMD_FREE;
                    req.start_offset = '0;
                end
                2: begin
                    req.command      = CMD_FREE;
                    req.request_size = ADDR_W'($urandom);
                end
                default: req.request_size = ADDR_W'($urandom);
            endcase
            return req;
        end
        idx = (ledger.ext_count > 0) ? $urandom_range(ledger.ext_count - 1) : 0;
        if (roll < 5 + free_pct) begin
            req.command      = CMD_FREE;
            req.start_offset = ADDR_W'($urandom_range(1, 32'hFF_EFFF));
            if (ledger.ext_count > 0) begin
                tail = {1'b0, ledger.ext_start[idx]} + ledger.ext_len[idx];
                case ($urandom_range(3))
                    0: begin
                        // Join onto the end, sometimes filling the gap to the next extent
                        if (!tail[ADDR_W]) begin
                            req.start_offset = tail[ADDR_W-1:0];
                            if (idx + 1 < ledger.ext_count && $urandom_range(1) == 1 &&
                                {1'b0, ledger.ext_start[idx + 1]} > tail)
                                req.request_size =
                                    ADDR_W'({1'b0, ledger.ext_start[idx + 1]} - tail);
                        end
                    end
                    1: begin
                        // Join onto the front
                        if (ledger.ext_start[idx] > 1) begin
                            cap = ledger.ext_start[idx] - 1;
                            req.request_size = ADDR_W'($urandom_range(1,
                                                      (cap < 4096) ? cap : 4096));
                            req.start_offset = ledger.ext_start[idx] - req.request_size;
                        end
                    end
                    default: ;
                endcase
            end
        end else if (ledger.ext_count > 0) begin
            case ($urandom_range(3))
                0: req.request_size = ledger.ext_len[idx];
                1: begin
                    if (ledger.ext_len[idx] > 1)
                        req.request_size = ADDR_W'($urandom_range(1, ledger.ext_len[idx] - 1));
                end
                2: req.request_size = ADDR_W'($urandom);
                default: ;
            endcase
        end
        return req;
    endfunction

    // Offer one request beat after a random gap and hold it until accepted
    task automatic send_request(input t_request req);
        int unsigned gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        ledger.take_request(req);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        ledger.set_limit(value);
    endtask

    task automatic wait_drained();
        while (ledger.pending() != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [LIMIT_W-1:0] limit, input int unsigned idle,
                             input int unsigned stall, input int unsigned beats,
                             input int unsigned free_pct, input bit flood,
                             input bit long_hold);
        send_idle_pct = idle;
        stall_pct     = stall;
        write_limit(limit);
        if (long_hold) hold_asked <= hold_asked + 1;
        repeat (beats) send_request(pick_request(free_pct, flood));
        i_in_valid <= 1'b0;
        wait_drained();
    endtask

    // Walk through the edge cases by hand
    task automatic run_directed();
        send_request(make_beat(CMD_ALLOC, 32'hFF_FFFF, 5));     // empty map: no fit
        send_request(make_beat(CMD_ALLOC, 7, 0));               // zero size
        send_request(make_beat(CMD_FREE, 0, 10));               // zero offset
        send_request(make_beat(CMD_FREE, 100, 0));              // zero size on free
        send_request(make_beat(CMD_FREE, 32'hFF_FFFF, 2));      // runs past the top
        send_request(make_beat(CMD_FREE, 32'hFF_FFFF, 1));      // ends exactly at the top
        send_request(make_beat(CMD_FREE, 1000, 100));           // insert in front
        send_request(make_beat(CMD_FREE, 1100, 50));            // join onto the end
        send_request(make_beat(CMD_FREE, 900, 100));            // join onto the front
        send_request(make_beat(CMD_FREE, 2000, 10));            // insert in the middle
        send_request(make_beat(CMD_FREE, 1150, 850));           // bridge two extents
        send_request(make_beat(CMD_ALLOC, 0, 60));              // trim
        send_request(make_beat(CMD_ALLOC, 0, 800));             // trim again
        send_request(make_beat(CMD_ALLOC, 0, 2));               // fits the first extent
        send_request(make_beat(CMD_ALLOC, 0, 1));               // fits the first extent
        send_request(make_beat(CMD_FREE, 5, 5));
        send_request(make_beat(CMD_FREE, 20, 5));
        send_request(make_beat(CMD_FREE, 40, 5));
        i_in_valid <= 1'b0;
        wait_drained();
        // Lower the limit below the count: inserts are lost, merges still go through
        write_limit(LIMIT_W'(2));
        send_request(make_beat(CMD_FREE, 60, 5));
        send_request(make_beat(CMD_FREE, 45, 5));
        send_request(make_beat(CMD_ALLOC, 0, 32'hFF_FFFF));
        send_request(make_beat(CMD_FREE, 1, 32'hFF_FFFF));
        i_in_valid <= 1'b0;
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_limit(LIMIT_W'(32));
        run_directed();

        // limit, sender idle %, receiver stall %, beats, free %, flood, long hold
        run_phase(LIMIT_W'(32), 0, 0, 300, 62, 1'b0, 1'b0);
        run_phase(LIMIT_W'(1), 82, 0, 170, 50, 1'b0, 1'b0);
        run_phase(LIMIT_W'(4), 0, 82, 230, 55, 1'b0, 1'b1);
        run_phase(LIMIT_W'(63), 19, 19, 130, 60, 1'b0, 1'b0);
        run_phase(LIMIT_W'(63), 19, 19, 130, 45, 1'b0, 1'b0);
        run_phase(LIMIT_W'(0), 19, 19, 300, 50, 1'b1, 1'b0);
        run_phase(LIMIT_W'($urandom_range(1, 32)), 19, 19, 150, 55, 1'b0, 1'b0);

        // Let any stray result beat show up before the verdict
        repeat (ENTRIES + 8) @(posedge i_clk);
        if (ledger.mismatches == 0 && ledger.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
